>>> rtl/core/crc16_frame_append_check_top_assert.svh
// Assertion macros for the CRC-16 frame block.
// Each macro checks a property on i_clk, held off while i_rst_n is low.
`ifndef CRC16_FRAME_APPEND_CHECK_TOP_ASSERT_SVH
`define CRC16_FRAME_APPEND_CHECK_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define CRCFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("crcfa: same-cycle check failed");

// Next-cycle implication
`define CRCFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("crcfa: next-cycle check failed");

`else

`define CRCFA_ASSERT_NOW(label, ante, cons)
`define CRCFA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/crcfa_pkg.sv
package crcfa_pkg;

    // Reflected CRC-16/ARC polynomial
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam int          RES_SLOTS = 3;

    typedef enum logic {
        MODE_APPEND = 1'b0,
        MODE_CHECK  = 1'b1
    } t_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       frame_end;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_verdict;
        logic       crc_ok;
        logic       out_last;
    } t_result;

    // Results produced by one input item, slot 0 goes out first
    typedef struct packed {
        logic [1:0]                    n;
        t_result [RES_SLOTS-1:0]       res;
    } t_load;

    // One byte step of the reflected CRC, LSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/crcfa_in_reg.sv
module crcfa_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  crcfa_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output crcfa_pkg::t_item o_item
);
    import crcfa_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // Accept when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    // Hold the item until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/core/crcfa_core.sv
module crcfa_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  crcfa_pkg::t_item i_item,
    input  logic             i_can_load,
    output logic             o_take,
    output crcfa_pkg::t_load o_load
);
    import crcfa_pkg::*;

    logic        r_in_frame;
    t_mode       r_frame_mode;
    logic [15:0] r_crc_acc;
    logic [7:0]  r_held_bytes [2];
    logic [1:0]  r_held_count;

    logic        n_in_frame;
    t_mode       n_frame_mode;
    logic [15:0] n_crc_acc;
    logic [7:0]  n_held_bytes [2];
    logic [1:0]  n_held_count;

    logic        first;
    t_mode       mode;
    logic [15:0] base_crc;
    logic [7:0]  hb0;
    logic [7:0]  hb1;
    logic [1:0]  hc;
    logic [7:0]  crc_byte;
    logic [15:0] crc_next;
    logic        ok;

    assign o_take = i_item_valid && i_can_load;

    // Start of frame restarts the CRC and the delay line
    always_comb begin
        first    = !r_in_frame;
        mode     = first ? t_mode'(i_item.op) : r_frame_mode;
        base_crc = first ? 16'h0000 : r_crc_acc;
        hb0      = first ? 8'h00 : r_held_bytes[0];
        hb1      = first ? 8'h00 : r_held_bytes[1];
        hc       = first ? 2'd0 : r_held_count;
        crc_byte = (mode == MODE_APPEND) ? i_item.data_byte : hb0;
        crc_next = crc_update(base_crc, crc_byte);
    end

    // Next state and results for the current item
    always_comb begin
        n_in_frame      = !i_item.frame_end;
        n_frame_mode    = mode;
        n_crc_acc       = base_crc;
        n_held_bytes[0] = hb0;
        n_held_bytes[1] = hb1;
        n_held_count    = hc;
        ok              = 1'b0;
        o_load          = '0;
        unique case (mode)
            MODE_APPEND: begin
                n_crc_acc               = crc_next;
                o_load.res[0].out_byte  = i_item.data_byte;
                if (i_item.frame_end) begin
                    o_load.n                = 2'd3;
                    o_load.res[1].out_byte  = crc_next[7:0];
                    o_load.res[2].out_byte  = crc_next[15:8];
                    o_load.res[2].out_last  = 1'b1;
                end else begin
                    o_load.n = 2'd1;
                end
            end
            MODE_CHECK: begin
                if (hc[1]) begin
                    // Delay line full: oldest byte enters the CRC
                    n_crc_acc       = crc_next;
                    n_held_bytes[0] = hb1;
                    n_held_bytes[1] = i_item.data_byte;
                    n_held_count    = 2'd2;
                end else begin
                    if (hc[0]) begin
                        n_held_bytes[1] = i_item.data_byte;
                    end else begin
                        n_held_bytes[0] = i_item.data_byte;
                    end
                    n_held_count = hc + 2'd1;
                end
                ok = (n_held_count == 2'd2)
                     && (n_held_bytes[0] == n_crc_acc[7:0])
                     && (n_held_bytes[1] == n_crc_acc[15:8]);
                if (i_item.frame_end) begin
                    o_load.n                 = 2'd1;
                    o_load.res[0].is_verdict = 1'b1;
                    o_load.res[0].crc_ok     = ok;
                    o_load.res[0].out_last   = 1'b1;
                end
            end
            default: begin
                o_load = '0;
            end
        endcase
    end

    // Advance frame state on each transfer into the result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame      <= 1'b0;
            r_frame_mode    <= MODE_APPEND;
            r_crc_acc       <= 16'h0000;
            r_held_bytes[0] <= 8'h00;
            r_held_bytes[1] <= 8'h00;
            r_held_count    <= 2'd0;
        end else if (o_take) begin
            r_in_frame      <= n_in_frame;
            r_frame_mode    <= n_frame_mode;
            r_crc_acc       <= n_crc_acc;
            r_held_bytes[0] <= n_held_bytes[0];
            r_held_bytes[1] <= n_held_bytes[1];
            r_held_count    <= n_held_count;
        end
    end

endmodule

>>> rtl/core/crcfa_out_buf.sv
module crcfa_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_valid,
    input  crcfa_pkg::t_load   i_load,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output crcfa_pkg::t_result o_result
);
    import crcfa_pkg::*;

    logic [1:0]              r_cnt;
    logic [1:0]              n_cnt;
    t_result [RES_SLOTS-1:0] r_res;
    t_result [RES_SLOTS-1:0] n_res;
    logic                    pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_result   = r_res[0];
    assign pop        = o_valid && i_ready;
    // Room for a new group once the buffer drains this cycle
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    // Load a new group or shift toward the head on each transfer
    always_comb begin
        n_cnt = r_cnt;
        n_res = r_res;
        if (i_load_valid) begin
            n_cnt = i_load.n;
            n_res = i_load.res;
        end else if (pop) begin
            n_cnt    = r_cnt - 2'd1;
            n_res[0] = r_res[1];
            n_res[1] = r_res[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

>>> rtl/core/crc16_frame_append_check_top.sv
// Channel   Valid         Ready         Payload
// input     i_in_valid    o_in_ready    i_op, i_data_byte, i_frame_end
// output    o_out_valid   i_out_ready   o_out_byte, o_is_verdict, o_crc_ok, o_out_last
//
// One byte per cycle enters while the result buffer has room; it is held in the input
// register, and its first result is then registered into the result buffer and offered.
// The last byte of an append frame yields three results, so input waits while the
// three-entry result buffer drains; that buffer sets the rate.
// Check frames give no result until the last byte, which gives the verdict.
// i_rst_n is synchronous and active low; it clears frame state and both buffers.
// A stalled output backs up through the result buffer into the input register.
module crc16_frame_append_check_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_verdict,
    output logic       o_crc_ok,
    output logic       o_out_last
);
    import crcfa_pkg::*;

    t_item   in_item;
    t_item   reg_item;
    logic    reg_valid;
    logic    take;
    logic    can_load;
    t_load   load;
    t_result result;

    assign in_item.op        = i_op;
    assign in_item.data_byte = i_data_byte;
    assign in_item.frame_end = i_frame_end;

    // Input register
    crcfa_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .i_take  (take),
        .o_item  (reg_item)
    );

    // Frame state and CRC update
    crcfa_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (reg_valid),
        .i_item       (reg_item),
        .i_can_load   (can_load),
        .o_take       (take),
        .o_load       (load)
    );

    // Result buffer
    crcfa_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (take),
        .i_load       (load),
        .o_can_load   (can_load),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_result     (result)
    );

    assign o_out_byte   = result.out_byte;
    assign o_is_verdict = result.is_verdict;
    assign o_crc_ok     = result.crc_ok;
    assign o_out_last   = result.out_last;

`include "crc16_frame_append_check_top_assert.svh"

    // An item yields zero, one or three results, never two
    `CRCFA_ASSERT_NOW(a_load_count, take, load.n != 2'd2)
    // A verdict always closes its frame
    `CRCFA_ASSERT_NOW(a_verdict_last, o_out_valid && o_is_verdict, o_out_last)
    // Append results never claim a match
    `CRCFA_ASSERT_NOW(a_append_no_ok, o_out_valid && !o_is_verdict, !o_crc_ok)
    // A loaded group of results is offered on the output in the next cycle
    `CRCFA_ASSERT_NEXT(a_load_shows, take && (load.n != 2'd0), o_out_valid)

endmodule

>>> bench/crc16_frame_append_check_top_tb.sv
`timescale 1ns / 1ps

module crc16_frame_append_check_top_tb;
    import crcfa_pkg::*;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_op        = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_frame_end = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_is_verdict;
    logic       o_crc_ok;
    logic       o_out_last;

    crc16_frame_append_check_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .i_frame_end  (i_frame_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_is_verdict (o_is_verdict),
        .o_crc_ok     (o_crc_ok),
        .o_out_last   (o_out_last)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the frame state
    logic [15:0] crc_run;
    logic        frame_open;
    t_mode       frame_kind;
    logic [7:0]  tail_bytes [2];
    logic [1:0]  tail_cnt;

    t_result     frame_out_q [$];
    logic [7:0]  frame_buf [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    bit          input_idle = 1'b1;
    int          ready_mode = 0;
    int          ready_left = 0;
    int          ready_phase = 0;

    // Advance the CRC-16/ARC register by one byte, feeding bits LSB first
    function automatic logic [15:0] arc_crc_step(input logic [15:0] acc,
                                                 input logic [7:0]  b);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Queue the results one accepted byte produces
    task automatic model_frame_byte(input t_mode op, input logic [7:0] b,
                                    input logic eof);
        t_result r;
        logic    ok;
        if (!frame_open) begin
            frame_kind    = op;
            crc_run       = 16'h0000;
            tail_cnt      = 2'd0;
            tail_bytes[0] = 8'h00;
            tail_bytes[1] = 8'h00;
            frame_open    = 1'b1;
        end
        if (frame_kind == MODE_APPEND) begin
            crc_run = arc_crc_step(crc_run, b);
            r = '{out_byte: b, is_verdict: 1'b0, crc_ok: 1'b0, out_last: 1'b0};
            frame_out_q.push_back(r);
            if (eof) begin
                r.out_byte = crc_run[7:0];
                frame_out_q.push_back(r);
                r.out_byte = crc_run[15:8];
                r.out_last = 1'b1;
                frame_out_q.push_back(r);
            end
        end else begin
            // Shift the two-byte tail; the byte leaving it joins the CRC
            if (tail_cnt == 2'd2) begin
                crc_run       = arc_crc_step(crc_run, tail_bytes[0]);
                tail_bytes[0] = tail_bytes[1];
                tail_bytes[1] = b;
            end else begin
                tail_bytes[tail_cnt[0]] = b;
                tail_cnt = tail_cnt + 2'd1;
            end
            if (eof) begin
                ok = (tail_cnt == 2'd2) && (tail_bytes[0] == crc_run[7:0])
                     && (tail_bytes[1] == crc_run[15:8]);
                r = '{out_byte: 8'h00, is_verdict: 1'b1, crc_ok: ok, out_last: 1'b1};
                frame_out_q.push_back(r);
            end
        end
        if (eof) begin
            frame_open = 1'b0;
        end
    endtask

    // Drive one byte and hold it until the transfer completes
    task automatic send_byte(input t_mode op, input logic [7:0] b, input logic eof);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                if (!input_idle) begin
                    i_in_valid <= 1'b0;
                    input_idle = 1'b1;
                end
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        i_frame_end <= eof;
        input_idle  = 1'b0;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        burst_left--;
        bytes_sent++;
        model_frame_byte(op, b, eof);
    endtask

    // Drop valid in the step of the last transfer
    task automatic hold_input;
        if (!input_idle) begin
            i_in_valid <= 1'b0;
            input_idle = 1'b1;
        end
    endtask

    // Hold the sender until every queued result has come out
    task automatic wait_drained;
        hold_input();
        @(posedge i_clk);
        while (frame_out_q.size() != 0) @(posedge i_clk);
    endtask

    // Append the correct CRC of the buffer, low byte first
    task automatic add_crc_tail;
        logic [15:0] c;
        c = 16'h0000;
        foreach (frame_buf[i]) c = arc_crc_step(c, frame_buf[i]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    // Send the buffer as one frame; later bytes may carry a random op
    task automatic send_frame(input t_mode kind, input bit scramble_op);
        t_mode op;
        for (int i = 0; i < frame_buf.size(); i++) begin
            op = (i == 0 || !scramble_op) ? kind : t_mode'($urandom_range(0, 1));
            send_byte(op, frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    task automatic test_append_frames;
        frame_buf = '{8'h00};
        send_frame(MODE_APPEND, 1'b0);
        frame_buf = '{8'hFF};
        send_frame(MODE_APPEND, 1'b0);
        frame_buf = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
        send_frame(MODE_APPEND, 1'b0);
    endtask

    task automatic test_check_frames;
        // Good trailing CRC
        frame_buf = '{8'h80};
        add_crc_tail();
        send_frame(MODE_CHECK, 1'b0);
        // Corrupted high CRC byte
        frame_buf = '{8'h01};
        add_crc_tail();
        frame_buf[2] = frame_buf[2] ^ 8'h40;
        send_frame(MODE_CHECK, 1'b0);
        // Two-byte frames: only zero bytes match the empty CRC
        frame_buf = '{8'h00, 8'h00};
        send_frame(MODE_CHECK, 1'b0);
        frame_buf = '{8'h01, 8'h00};
        send_frame(MODE_CHECK, 1'b0);
    endtask

    task automatic test_short_check_frame;
        frame_buf = '{8'hFF};
        send_frame(MODE_CHECK, 1'b0);
    endtask

    // Op after the first byte must not change the frame mode
    task automatic test_mode_ignored;
        send_byte(MODE_APPEND, 8'h12, 1'b0);
        send_byte(MODE_CHECK, 8'h34, 1'b0);
        send_byte(MODE_CHECK, 8'h56, 1'b1);
        frame_buf = '{8'h7E};
        add_crc_tail();
        send_byte(MODE_CHECK, frame_buf[0], 1'b0);
        send_byte(MODE_APPEND, frame_buf[1], 1'b0);
        send_byte(MODE_APPEND, frame_buf[2], 1'b1);
    endtask

    task automatic test_random_traffic;
        int    stop_at;
        int    len;
        int    frames;
        int    idx;
        t_mode kind;
        stop_at = bytes_sent + 360;
        frames  = 0;
        while (bytes_sent < stop_at) begin
            frames++;
            kind = ($urandom_range(0, 1) != 0) ? MODE_CHECK : MODE_APPEND;
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                               : $urandom_range(1, 6);
            frame_buf.delete();
            if (kind == MODE_CHECK && $urandom_range(0, 9) < 7) begin
                // Well-formed check frame, sometimes with one bit flipped
                repeat (len - 1) frame_buf.push_back(8'($urandom_range(0, 255)));
                add_crc_tail();
                if ($urandom_range(0, 4) == 0) begin
                    idx = $urandom_range(0, frame_buf.size() - 1);
                    frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
                end
            end else begin
                repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            send_frame(kind, 1'b1);
            if (frames % 17 == 0) begin
                wait_drained();
            end
        end
    endtask

    // Receiver: alternate stretches of always ready, random and periodic stalls
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(4, 40);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                i_out_ready <= (ready_phase % 5) < 2;
            end
        endcase
    end

    // Compare each output transfer with the oldest queued result
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_out_q.size() == 0) begin
                $error("unexpected output transfer: out_byte %0h", o_out_byte);
                mismatches++;
            end else begin
                want = frame_out_q.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, o_out_byte);
                    mismatches++;
                end
                if (o_is_verdict !== want.is_verdict) begin
                    $error("is_verdict: expected %0b, got %0b", want.is_verdict,
                           o_is_verdict);
                    mismatches++;
                end
                if (o_crc_ok !== want.crc_ok) begin
                    $error("crc_ok: expected %0b, got %0b", want.crc_ok, o_crc_ok);
                    mismatches++;
                end
                if (o_out_last !== want.out_last) begin
                    $error("out_last: expected %0b, got %0b", want.out_last, o_out_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        frame_open = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_append_frames();
        test_check_frames();
        test_short_check_frame();
        test_mode_ignored();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && frame_out_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/crcfa_pkg.sv
rtl/core/crcfa_in_reg.sv
rtl/core/crcfa_core.sv
rtl/core/crcfa_out_buf.sv
rtl/core/crc16_frame_append_check_top.sv
bench/crc16_frame_append_check_top_tb.sv
